### hw/rtl/gn3_pkg.sv
`default_nettype none
package gn3_pkg;

  localparam int unsigned TableSizeDef = 256;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned GradW        = 16;
  localparam int unsigned PermW        = 8;

  typedef enum logic [2:0] {
    OpEval   = 3'd0,
    OpWrPermX = 3'd1,
    OpWrPermY = 3'd2,
    OpWrPermZ = 3'd3,
    OpWrGrad  = 3'd4
  } opcode_e;

endpackage
`default_nettype wire

### hw/rtl/gn3_ram.sv
`default_nettype none
module gn3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr0_i,
  input  wire logic [$clog2(Depth)-1:0] raddr1_i,
  output logic      [Width-1:0]         rdata0_o,
  output logic      [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem [Depth];

  // read returns the old word on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gradient_noise_3d_top.sv
`default_nettype none
// an accepted evaluate item passes stages 1 to 7, then the output register
// one item per cycle unless stalled; corner lookups use duplicated dual-read table rams
// write items give no result
// the pipeline freezes as a whole while the output item is stalled
// reset clears the pipeline valid bits only; table contents are undefined until written
module gradient_noise_3d_top #(
  parameter int unsigned TABLE_SIZE = gn3_pkg::TableSizeDef,
  parameter int unsigned FRAC_BITS  = gn3_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [7:0]         entry_index_i,
  input  wire logic [7:0]         perm_value_i,
  input  wire logic signed [15:0] grad_x_i,
  input  wire logic signed [15:0] grad_y_i,
  input  wire logic signed [15:0] grad_z_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      noise_value_o
);
  import gn3_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned GW = 3 * GradW;
  localparam int unsigned PW = F + 17;
  localparam int unsigned SW = 2 * F + 9;

  opcode_e op;
  logic    en, accept;
  logic [AW-1:0] widx;

  assign op         = opcode_e'(opcode_i);
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign widx       = AW'(32'(entry_index_i));

  logic signed [31:0] pt [3];
  logic signed [63:0] pe [3];
  logic [AW-1:0] ix0 [3];
  logic [AW-1:0] ix1 [3];
  logic [F-1:0]  frac_in [3];
  logic [PermW-1:0] pq0 [3];
  logic [PermW-1:0] pq1 [3];
  logic [2:0] perm_we;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign perm_we[0] = accept && (op == OpWrPermX);
  assign perm_we[1] = accept && (op == OpWrPermY);
  assign perm_we[2] = accept && (op == OpWrPermZ);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign pe[a]      = 64'(pt[a]);
    assign ix0[a]     = pe[a][F +: AW];
    assign ix1[a]     = ix0[a] + AW'(1);
    assign frac_in[a] = pt[a][F-1:0];

    gn3_ram #(.Width(PermW), .Depth(TABLE_SIZE)) u_perm (
      .clk_i    (clk_i),
      .we_i     (perm_we[a]),
      .waddr_i  (widx),
      .wdata_i  (perm_value_i),
      .re_i     (en),
      .raddr0_i (ix0[a]),
      .raddr1_i (ix1[a]),
      .rdata0_o (pq0[a]),
      .rdata1_o (pq1[a])
    );
  end

  // stage 1: permutation data out
  logic         v1_q;
  logic [F-1:0] f1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept && (op == OpEval);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) f1_q[a] <= frac_in[a];
    end
  end

  // corner c = {di, dj, dk}
  logic [AW-1:0] hsh [8];
  logic [PermW-1:0] hv;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      hv = (c[2] ? pq1[0] : pq0[0]) ^ (c[1] ? pq1[1] : pq0[1]) ^ (c[0] ? pq1[2] : pq0[2]);
      hsh[c] = AW'(32'(hv));
    end
  end

  logic [GW-1:0] gq [8];
  logic          grad_we;
  logic [GW-1:0] grad_wd;

  assign grad_we = accept && (op == OpWrGrad);
  assign grad_wd = {grad_z_i, grad_y_i, grad_x_i};

  for (genvar k = 0; k < 4; k++) begin : g_grad
    gn3_ram #(.Width(GW), .Depth(TABLE_SIZE)) u_grad (
      .clk_i    (clk_i),
      .we_i     (grad_we),
      .waddr_i  (widx),
      .wdata_i  (grad_wd),
      .re_i     (en),
      .raddr0_i (hsh[2*k]),
      .raddr1_i (hsh[2*k+1]),
      .rdata0_o (gq[2*k]),
      .rdata1_o (gq[2*k+1])
    );
  end

  // stage 2: gradient data out, fraction squared
  logic           v2_q;
  logic [F-1:0]   f2_q [3];
  logic [F-1:0]   sq2_q [3];
  logic [2*F-1:0] sqp [3];

  always_comb begin
    for (int a = 0; a < 3; a++) sqp[a] = (2*F)'(f1_q[a]) * (2*F)'(f1_q[a]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        f2_q[a]  <= f1_q[a];
        sq2_q[a] <= sqp[a][2*F-1:F];
      end
    end
  end

  // stage 3: gradient products and smoothstep
  logic                 v3_q;
  logic signed [PW-1:0] p3_q [8][3];
  logic [F:0]           s3_q [3];
  logic signed [F:0]    dv [8][3];
  logic signed [15:0]   gc [8][3];
  logic [F+1:0]         tv [3];
  logic [2*F+1:0]       smp [3];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      for (int a = 0; a < 3; a++) begin
        gc[c][a] = gq[c][a*GradW +: GradW];
        if (((c >> (2 - a)) & 1) != 0) begin
          dv[c][a] = {1'b0, f2_q[a]} - {1'b1, {F{1'b0}}};
        end else begin
          dv[c][a] = {1'b0, f2_q[a]};
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      tv[a]  = {2'b11, {F{1'b0}}} - {1'b0, f2_q[a], 1'b0};
      smp[a] = (2*F+2)'(sq2_q[a]) * (2*F+2)'(tv[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        for (int a = 0; a < 3; a++) p3_q[c][a] <= PW'(gc[c][a]) * PW'(dv[c][a]);
      end
      for (int a = 0; a < 3; a++) s3_q[a] <= smp[a][2*F:F];
    end
  end

  // stage 4: dot products and xy weights
  logic                  v4_q;
  logic signed [F+4:0]   dot4_q [8];
  logic [F:0]            wxy4_q [4];
  logic [F:0]            sz4_q;
  logic signed [F+18:0]  dsum [8];
  logic [F:0]            wx, wy;
  logic [2*F+1:0]        wxyp [4];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      dsum[c] = (F+19)'(p3_q[c][0]) + (F+19)'(p3_q[c][1]) + (F+19)'(p3_q[c][2]);
    end
    for (int j = 0; j < 4; j++) begin
      wx = j[1] ? s3_q[0] : ({1'b1, {F{1'b0}}} - s3_q[0]);
      wy = j[0] ? s3_q[1] : ({1'b1, {F{1'b0}}} - s3_q[1]);
      wxyp[j] = (2*F+2)'(wx) * (2*F+2)'(wy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) dot4_q[c] <= dsum[c][F+18:14];
      for (int j = 0; j < 4; j++) wxy4_q[j] <= wxyp[j][2*F:F];
      sz4_q <= s3_q[2];
    end
  end

  // stage 5: full corner weights
  logic                v5_q;
  logic signed [F+4:0] dot5_q [8];
  logic [F:0]          w5_q [8];
  logic [F:0]          wz;
  logic [2*F+1:0]      wp [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      wz = c[0] ? sz4_q : ({1'b1, {F{1'b0}}} - sz4_q);
      wp[c] = (2*F+2)'(wxy4_q[c >> 1]) * (2*F+2)'(wz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        dot5_q[c] <= dot4_q[c];
        w5_q[c]   <= wp[c][2*F:F];
      end
    end
  end

  // stage 6: weighted terms
  logic                   v6_q;
  logic signed [2*F+5:0]  term6_q [8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        term6_q[c] <= (2*F+6)'(dot5_q[c]) * (2*F+6)'($signed({1'b0, w5_q[c]}));
      end
    end
  end

  // stage 7: partial sums of four terms
  logic                  v7_q;
  logic signed [2*F+7:0] part7_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int h = 0; h < 2; h++) begin
        part7_q[h] <= (2*F+8)'(term6_q[4*h]) + (2*F+8)'(term6_q[4*h+1])
                    + (2*F+8)'(term6_q[4*h+2]) + (2*F+8)'(term6_q[4*h+3]);
      end
    end
  end

  // output: total, rescale to q1.15, saturate
  logic signed [SW-1:0] tot, shr;
  logic signed [15:0]   noise_d;

  always_comb begin
    tot = SW'(part7_q[0]) + SW'(part7_q[1]);
    shr = tot >>> (2*F - 15);
    if (shr > $signed(SW'(32767))) begin
      noise_d = 16'sh7fff;
    end else if (shr < $signed(SW'(-32768))) begin
      noise_d = 16'sh8000;
    end else begin
      noise_d = shr[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_value_o <= noise_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_o <= v7_q;
    end
  end

endmodule
`default_nettype wire
